FILE: rtl/real_spherical_harmonic_sample_assert.svh
// assertion macros for the spherical harmonic sampler
// used by real_spherical_harmonic_sample.sv, no other dependencies
`ifndef REAL_SPHERICAL_HARMONIC_SAMPLE_ASSERT_SVH
`define REAL_SPHERICAL_HARMONIC_SAMPLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RSHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rshs check failed");

// next-cycle implication, checked out of reset
`define RSHS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rshs check failed");

`endif

FILE: rtl/rshs_pkg.sv
// shared constants, types and tables of the spherical harmonic sampler
// no dependencies; used by every module of the block but rshs_mul
package rshs_pkg;

    localparam int BAND_COUNT   = 8;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;

    // cordic datapath width, room for gain growth and the angle residue
    localparam int CORDIC_W = 34;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [63:0]         ONE_Q32     = 64'sd4294967296;
    localparam logic signed [63:0]         SQRT2_Q30   = 64'sd1518500250;
    localparam logic [63:0]                INV4PI_Q40  = 64'd87496355274;

    // arctangents as truncated fractions of a turn
    localparam logic [31:0] ATAN_TURN [30] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    // rounded 2^32/k, Q0.32
    localparam logic signed [63:0] RECIP_Q32 [8] = '{
        64'sd0, 64'sd0, 64'sd2147483648, 64'sd1431655765, 64'sd1073741824,
        64'sd858993459, 64'sd715827883, 64'sd613566757
    };

    // pipeline shape
    localparam int MUL_LAT    = 2;
    localparam int PHASE_LAT  = MUL_LAT + 1;
    localparam int PMM_STEPS  = BAND_COUNT - 1;
    localparam int REC_STEPS  = (BAND_COUNT > 2) ? BAND_COUNT - 2 : 0;
    localparam int LEG_PHASES = PMM_STEPS + 1 + 2 * REC_STEPS;
    localparam int LEG_LAT    = LEG_PHASES * PHASE_LAT;
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int TOTAL_LAT  = 1 + CORDIC_LAT + LEG_LAT + 2 * MUL_LAT + 1;

    // per-word control that rides along the pipeline
    typedef struct packed {
        logic       valid;
        logic       invalid;
        logic       order_zero;
        logic       order_neg;
        logic [2:0] band;
        logic [2:0] mag;
    } side_t;

    // legendre recurrence state, all Q31.32
    typedef struct packed {
        side_t              side;
        logic signed [63:0] x;
        logic signed [63:0] s;
        logic signed [63:0] pmm;
        logic signed [63:0] pmp1m;
        logic signed [63:0] diff;
    } leg_t;

    typedef logic [63:0][63:0] norm_tab_t;

    function automatic logic [63:0] fact(input int n);
        logic [63:0] f;
        f = 64'd1;
        for (int k = 2; k <= 14; k++)
        begin
            if (k <= n)
            begin
                f = f * 64'(k);
            end
        end
        return f;
    endfunction

    // K(l,m) in Q2.60, evaluated at elaboration only
    function automatic logic [63:0] norm_q60(input int l, input int m);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        int          e;
        int          half;
        int          lm;
        num = 64'(2 * l + 1) * fact(l - m) * INV4PI_Q40;
        lm  = (l + m < 15) ? l + m : 14;
        den = fact(lm);
        q   = '0;
        r   = '0;
        // restoring long division
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        // extend the quotient to an even exponent with 60+ bits
        e = 40;
        for (int it = 0; it < 160; it++)
        begin
            if ((q < (64'd1 << 60) || e[0]) && e < 200)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r    = r - den;
                    q[0] = 1'b1;
                end
                e = e + 1;
            end
        end
        // integer square root
        n     = q;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int it = 0; it < 32; it++)
        begin
            if (bit_v > n)
            begin
                bit_v = bit_v >> 2;
            end
        end
        for (int it = 0; it < 32; it++)
        begin
            if (bit_v != 64'd0)
            begin
                if (n >= res + bit_v)
                begin
                    n   = n - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        half = e >> 1;
        if (half <= 60)
        begin
            return res << (60 - half);
        end
        if (half - 60 < 64)
        begin
            return res >> (half - 60);
        end
        return 64'd0;
    endfunction

    function automatic norm_tab_t build_norm_tab();
        norm_tab_t t;
        for (int l = 0; l < 8; l++)
        begin
            for (int m = 0; m < 8; m++)
            begin
                t[l * 8 + m] = (m <= l) ? norm_q60(l, m) : 64'd0;
            end
        end
        return t;
    endfunction

    // normalization rom indexed by {band, |order|}
    localparam norm_tab_t NORM_TAB = build_norm_tab();

endpackage

FILE: rtl/rshs_mul.sv
// two-stage signed 64x64 multiply, product truncated toward zero and shifted
// depends on nothing but the clock; used by rshs_legendre and the top level
module rshs_mul (
    input  logic               clk,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic [6:0]         shift,
    output logic signed [63:0] p
);

    logic [63:0]        ua;
    logic [63:0]        ub;
    logic               neg_reg;
    logic [63:0]        p00_reg;
    logic [63:0]        p01_reg;
    logic [63:0]        p10_reg;
    logic [63:0]        p11_reg;
    logic [33:0]        mid;
    logic [63:0]        hi;
    logic [63:0]        lo;
    logic [127:0]       full;
    logic [63:0]        mag;
    logic signed [63:0] p_reg;

    // magnitudes and four 32x32 partial products
    assign ua = a[63] ? 64'(-a) : 64'(a);
    assign ub = b[63] ? 64'(-b) : 64'(b);

    always_ff @(posedge clk)
    begin
        neg_reg <= a[63] ^ b[63];
        p00_reg <= 64'(ua[31:0]) * 64'(ub[31:0]);
        p01_reg <= 64'(ua[31:0]) * 64'(ub[63:32]);
        p10_reg <= 64'(ua[63:32]) * 64'(ub[31:0]);
        p11_reg <= 64'(ua[63:32]) * 64'(ub[63:32]);
    end

    // combine, shift, restore the sign
    assign mid  = 34'(p00_reg[63:32]) + 34'(p01_reg[31:0]) + 34'(p10_reg[31:0]);
    assign lo   = {mid[31:0], p00_reg[31:0]};
    assign hi   = p11_reg + 64'(p01_reg[63:32]) + 64'(p10_reg[63:32]) + 64'(mid[33:32]);
    assign full = {hi, lo};
    assign mag  = full[63:0] >> shift | ((shift == 7'd0) ? 64'd0 : 64'(full >> shift));

    always_ff @(posedge clk)
    begin
        p_reg <= neg_reg ? -$signed(mag) : $signed(mag);
    end

    assign p = p_reg;

endmodule

FILE: rtl/rshs_cordic.sv
// pipelined rotation cordic: cos and sin of a 32-bit turn fraction in Q1.30
// depends on rshs_pkg for the gain, width and arctangent table
module rshs_cordic (
    input  logic               clk,
    input  logic [31:0]        turn,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    localparam int CW = rshs_pkg::CORDIC_W;
    localparam int N  = rshs_pkg::CORDIC_STEPS;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } rot_t;

    rot_t                 rot_reg [N+1];
    logic                 flip;
    logic [31:0]          a_turn;
    logic signed [CW-1:0] x_cl;
    logic signed [CW-1:0] y_cl;
    logic signed [31:0]   cos_reg;
    logic signed [31:0]   sin_reg;

    // fold the second and third quarter by half a turn
    assign flip   = turn[31] ^ turn[30];
    assign a_turn = flip ? turn - 32'h8000_0000 : turn;

    always_ff @(posedge clk)
    begin
        rot_reg[0].x    <= rshs_pkg::CORDIC_GAIN;
        rot_reg[0].y    <= '0;
        rot_reg[0].z    <= CW'($signed(a_turn));
        rot_reg[0].flip <= flip;
    end

    // one micro-rotation per stage
    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam logic signed [CW-1:0] ANG = CW'(rshs_pkg::ATAN_TURN[k]);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = $signed(rot_reg[k].y) >>> k;
        assign dy = $signed(rot_reg[k].x) >>> k;

        always_ff @(posedge clk)
        begin
            rot_reg[k+1].flip <= rot_reg[k].flip;
            if (!rot_reg[k].z[CW-1])
            begin
                rot_reg[k+1].x <= rot_reg[k].x - dx;
                rot_reg[k+1].y <= rot_reg[k].y + dy;
                rot_reg[k+1].z <= rot_reg[k].z - ANG;
            end
            else
            begin
                rot_reg[k+1].x <= rot_reg[k].x + dx;
                rot_reg[k+1].y <= rot_reg[k].y - dy;
                rot_reg[k+1].z <= rot_reg[k].z + ANG;
            end
        end
    end

    // clamp to [-1, 1]
    always_comb
    begin
        x_cl = rot_reg[N].x;
        y_cl = rot_reg[N].y;
        if (x_cl > rshs_pkg::ONE_Q30)
        begin
            x_cl = rshs_pkg::ONE_Q30;
        end
        if (x_cl < -rshs_pkg::ONE_Q30)
        begin
            x_cl = -rshs_pkg::ONE_Q30;
        end
        if (y_cl > rshs_pkg::ONE_Q30)
        begin
            y_cl = rshs_pkg::ONE_Q30;
        end
        if (y_cl < -rshs_pkg::ONE_Q30)
        begin
            y_cl = -rshs_pkg::ONE_Q30;
        end
    end

    // undo the fold
    always_ff @(posedge clk)
    begin
        cos_reg <= rot_reg[N].flip ? 32'(-x_cl) : 32'(x_cl);
        sin_reg <= rot_reg[N].flip ? 32'(-y_cl) : 32'(y_cl);
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

FILE: rtl/rshs_legendre.sv
// associated legendre value P(l,|m|) in Q31.32, unrolled into multiply phases
// depends on rshs_pkg and rshs_mul
module rshs_legendre (
    input  logic               clk,
    input  logic               rst_n,
    input  rshs_pkg::leg_t     in_data,
    output rshs_pkg::side_t    out_side,
    output logic signed [63:0] out_p
);

    localparam int NPH = rshs_pkg::LEG_PHASES;
    localparam int PMS = rshs_pkg::PMM_STEPS;

    rshs_pkg::leg_t stg [NPH+1];

    assign stg[0] = in_data;

    // each phase: one truncating multiply, then a small fix-up register
    for (genvar p = 0; p < NPH; p++)
    begin : g_phase
        rshs_pkg::leg_t     d1_reg;
        rshs_pkg::leg_t     d2_reg;
        rshs_pkg::leg_t     q_reg;
        rshs_pkg::leg_t     q_next;
        logic signed [63:0] op_a;
        logic signed [63:0] op_b;
        logic signed [63:0] prod;

        rshs_mul u_mul (
            .clk   (clk),
            .a     (op_a),
            .b     (op_b),
            .shift (7'd32),
            .p     (prod)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d1_reg <= '0;
                d2_reg <= '0;
                q_reg  <= '0;
            end
            else
            begin
                d1_reg <= stg[p];
                d2_reg <= d1_reg;
                q_reg  <= q_next;
            end
        end

        assign stg[p+1] = q_reg;

        if (p < PMS)
        begin : g_pmm
            // P(m,m) product, step i
            localparam int I = p + 1;
            localparam logic signed [63:0] F = 64'(2 * I - 1);
            always_comb
            begin
                op_a   = stg[p].pmm;
                op_b   = stg[p].s;
                q_next = d2_reg;
                if (4'(I) <= {1'b0, d2_reg.side.mag})
                begin
                    q_next.pmm = -(prod * F);
                end
            end
        end
        else if (p == PMS)
        begin : g_pm1
            // P(m+1,m) = x * P(m,m) * (2m+1)
            always_comb
            begin
                op_a         = stg[p].x;
                op_b         = stg[p].pmm;
                q_next       = d2_reg;
                q_next.pmp1m = prod * $signed(64'({d2_reg.side.mag, 1'b1}));
            end
        end
        else if (((p - PMS - 1) % 2) == 0)
        begin : g_reca
            // recurrence numerator x*P(i-1)*(2i-1) - P(i-2)*(i+m-1)
            localparam int J = (p - PMS - 1) / 2;
            logic [63:0] f_a;
            logic [63:0] f_b;
            assign f_a = 64'({d2_reg.side.mag, 1'b0}) + 64'(2 * J + 3);
            assign f_b = 64'({d2_reg.side.mag, 1'b0}) + 64'(J + 1);
            always_comb
            begin
                op_a        = stg[p].x;
                op_b        = stg[p].pmp1m;
                q_next      = d2_reg;
                q_next.diff = prod * $signed(f_a) - d2_reg.pmm * $signed(f_b);
            end
        end
        else
        begin : g_recb
            // divide by (i-m) through the reciprocal, then shift the window
            localparam int J = (p - PMS - 1) / 2;
            logic active;
            assign active = (5'(d2_reg.side.mag) + 5'(J + 2)) <= 5'(d2_reg.side.band);
            always_comb
            begin
                op_a   = stg[p].diff;
                op_b   = rshs_pkg::RECIP_Q32[J+2];
                q_next = d2_reg;
                if (active)
                begin
                    q_next.pmm   = d2_reg.pmp1m;
                    q_next.pmp1m = prod;
                end
            end
        end
    end

    // l == m leaves the product, otherwise the top of the window
    assign out_side = stg[NPH].side;
    assign out_p    = (stg[NPH].side.band == stg[NPH].side.mag) ?
                      stg[NPH].pmm : stg[NPH].pmp1m;

endmodule

FILE: rtl/real_spherical_harmonic_sample.sv
// top level of the real spherical harmonic sampler
// depends on rshs_pkg, rshs_cordic, rshs_legendre, rshs_mul and the assertion header
//
// Usage: drive band, order, polar_angle and azimuth_angle and raise start; the
// word is taken at the rising edge where start is high and busy is low. busy
// stays low, so a new word can be taken on every clock.
// Each word yields exactly one result word: done is high for one cycle with
// harmonic_value (Q3.28, saturated) and invalid. An order whose magnitude
// exceeds the band returns zero with invalid set.
// The path runs through one input register, the cordic stages of the angle
// units, the legendre multiply phases (20 phases), the normalization and azimuth
// multiplies and one output register. Throughput is one word per cycle; the
// chain of legendre multiplies sets the latency.
// Reset (rst_n low, asynchronous) empties the pipeline: no done pulse follows
// for words taken before it. The receiver cannot stall; results are shown
// once and must be taken in that cycle.
`include "real_spherical_harmonic_sample_assert.svh"
module real_spherical_harmonic_sample (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         band,
    input  logic signed [3:0]  order,
    input  logic [15:0]        polar_angle,
    input  logic [15:0]        azimuth_angle,
    output logic               done,
    output logic signed [31:0] harmonic_value,
    output logic               invalid
);

    localparam int CL = rshs_pkg::CORDIC_LAT;
    localparam int LL = rshs_pkg::LEG_LAT;
    localparam int AB = rshs_pkg::ANGLE_BITS;

    logic [3:0]         mag4;
    rshs_pkg::side_t    side_next;
    rshs_pkg::side_t    in_side_reg;
    logic [31:0]        theta_reg;
    logic [31:0]        phi_reg;
    rshs_pkg::side_t    side_dly_reg [CL];
    logic signed [31:0] ct;
    logic signed [31:0] st;
    logic signed [31:0] st_abs;
    logic signed [31:0] cp;
    logic signed [31:0] sp;
    logic signed [31:0] trig;
    logic signed [63:0] trig2;
    logic signed [31:0] trig_dly_reg [LL];
    rshs_pkg::leg_t     leg_in;
    rshs_pkg::side_t    leg_side;
    logic signed [63:0] leg_p;
    logic signed [63:0] v1;
    logic signed [63:0] v2;
    logic signed [63:0] v1_dly_reg [2];
    rshs_pkg::side_t    side_post_reg [4];
    rshs_pkg::side_t    fin_side;
    logic signed [63:0] vsel;
    logic [63:0]        vmag;
    logic signed [63:0] vq;
    logic signed [31:0] vsat;
    logic               done_reg;
    logic signed [31:0] value_reg;
    logic               invalid_reg;

    assign busy = 1'b0;

    // order magnitude and range check
    assign mag4 = order[3] ? 4'(-order) : 4'(order);

    always_comb
    begin
        side_next.valid      = start;
        side_next.invalid    = (mag4 > {1'b0, band}) ||
                               ({1'b0, band} >= 4'(rshs_pkg::BAND_COUNT));
        side_next.order_zero = (order == 4'sd0);
        side_next.order_neg  = order[3];
        side_next.band       = band;
        side_next.mag        = mag4[2:0];
    end

    // input register, angles as turn fractions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_side_reg <= '0;
        end
        else
        begin
            in_side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        theta_reg <= 32'(polar_angle) << (32 - AB);
        phi_reg   <= 32'((32'(azimuth_angle) << (32 - AB)) * 32'(mag4[2:0]));
    end

    rshs_cordic u_theta (
        .clk     (clk),
        .turn    (theta_reg),
        .cos_val (ct),
        .sin_val (st)
    );

    rshs_cordic u_phi (
        .clk     (clk),
        .turn    (phi_reg),
        .cos_val (cp),
        .sin_val (sp)
    );

    // control travels beside the cordic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CL; k++)
            begin
                side_dly_reg[k] <= '0;
            end
        end
        else
        begin
            side_dly_reg[0] <= in_side_reg;
            for (int k = 1; k < CL; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    // legendre inputs: x = cos, s = |sin|, both Q.32
    assign st_abs = st[31] ? -st : st;

    always_comb
    begin
        leg_in.side  = side_dly_reg[CL-1];
        leg_in.x     = $signed(64'(ct)) <<< 2;
        leg_in.s     = $signed(64'(st_abs)) <<< 2;
        leg_in.pmm   = rshs_pkg::ONE_Q32;
        leg_in.pmp1m = '0;
        leg_in.diff  = '0;
    end

    rshs_legendre u_leg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (leg_in),
        .out_side (leg_side),
        .out_p    (leg_p)
    );

    // azimuth term times sqrt2, held until the legendre value arrives
    assign trig = side_dly_reg[CL-1].order_neg ? sp : cp;

    rshs_mul u_sqrt2 (
        .clk   (clk),
        .a     ($signed(64'(trig))),
        .b     (rshs_pkg::SQRT2_Q30),
        .shift (7'd30),
        .p     (trig2)
    );

    always_ff @(posedge clk)
    begin
        trig_dly_reg[0] <= 32'(trig2);
        for (int k = 1; k < LL; k++)
        begin
            trig_dly_reg[k] <= trig_dly_reg[k-1];
        end
    end

    // normalization
    rshs_mul u_norm (
        .clk   (clk),
        .a     (leg_p),
        .b     ($signed(rshs_pkg::NORM_TAB[{leg_side.band, leg_side.mag}])),
        .shift (7'd60),
        .p     (v1)
    );

    // azimuth scaling
    rshs_mul u_trig (
        .clk   (clk),
        .a     (v1),
        .b     ($signed(64'(trig_dly_reg[LL-1]))),
        .shift (7'd30),
        .p     (v2)
    );

    always_ff @(posedge clk)
    begin
        v1_dly_reg[0] <= v1;
        v1_dly_reg[1] <= v1_dly_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                side_post_reg[k] <= '0;
            end
        end
        else
        begin
            side_post_reg[0] <= leg_side;
            for (int k = 1; k < 4; k++)
            begin
                side_post_reg[k] <= side_post_reg[k-1];
            end
        end
    end

    assign fin_side = side_post_reg[3];

    // Q.32 to Q3.28 toward zero, then saturate
    always_comb
    begin
        vsel = fin_side.order_zero ? v1_dly_reg[1] : v2;
        vmag = vsel[63] ? 64'(-vsel) : 64'(vsel);
        vq   = vsel[63] ? -$signed(vmag >> 4) : $signed(vmag >> 4);
        if (vq > 64'sd2147483647)
        begin
            vsat = 32'sh7FFF_FFFF;
        end
        else if (vq < -64'sd2147483648)
        begin
            vsat = 32'sh8000_0000;
        end
        else
        begin
            vsat = 32'(vq);
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= fin_side.valid;
            invalid_reg <= fin_side.invalid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= fin_side.invalid ? 32'sd0 : vsat;
    end

    assign done           = done_reg;
    assign harmonic_value = value_reg;
    assign invalid        = invalid_reg;

    `RSHS_ASSERT_IMP(a_invalid_zero, clk, rst_n, done && invalid, harmonic_value == 32'sd0)
    `RSHS_ASSERT_IMP(a_done_latency, clk, rst_n, done, $past(start, rshs_pkg::TOTAL_LAT))
    `RSHS_ASSERT_IMP(a_order_range, clk, rst_n, fin_side.valid && !fin_side.invalid, fin_side.mag <= fin_side.band)
    `RSHS_ASSERT_NXT(a_final_done, clk, rst_n, fin_side.valid, done)

endmodule

FILE: verif/tb_top.sv
// testbench for the real spherical harmonic sampler: directed and random words,
// predicted results checked in order against the done strobe
// depends on the rtl top level real_spherical_harmonic_sample only
`timescale 1ns / 100ps
module tb_top;

    typedef struct {
        logic [2:0]        band;
        logic signed [3:0] order;
        logic [15:0]       polar;
        logic [15:0]       azim;
    } sample_word_t;

    typedef struct {
        logic signed [31:0] value;
        logic               invalid;
    } harmonic_t;

    localparam int BANDS = 8;
    localparam int STEPS = 16;
    localparam int DRAIN_CYCLES = 150;

    localparam longint GAIN_Q30  = 652032874;
    localparam longint UNIT_Q30  = 1073741824;
    localparam longint UNIT_Q32  = 64'sd4294967296;
    localparam longint ROOT2_Q30 = 1518500250;
    localparam logic [63:0] INV_4PI_Q40 = 64'd87496355274;

    localparam logic [31:0] ARCTAN_TURN [16] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C
    };

    localparam longint INV_STEP_Q32 [8] = '{
        0, 0, 64'sd2147483648, 1431655765, 1073741824, 858993459, 715827883, 613566757
    };

    localparam logic [63:0] FACTORIAL [15] = '{
        1, 1, 2, 6, 24, 120, 720, 5040, 40320, 362880, 3628800, 39916800,
        479001600, 64'd6227020800, 64'd87178291200
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         band = '0;
    logic signed [3:0]  order = '0;
    logic [15:0]        polar_angle = '0;
    logic [15:0]        azimuth_angle = '0;
    logic               done;
    logic signed [31:0] harmonic_value;
    logic               invalid;

    sample_word_t pending_words[$];
    harmonic_t    expected_harmonics[$];
    int           sender_idle_pct = 0;
    int           mismatch_count = 0;

    real_spherical_harmonic_sample dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .band           (band),
        .order          (order),
        .polar_angle    (polar_angle),
        .azimuth_angle  (azimuth_angle),
        .done           (done),
        .harmonic_value (harmonic_value),
        .invalid        (invalid)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // product of a and b over 2^s, truncated toward zero, wrapping in 64 bits
    function automatic longint trunc_mul(input longint a, input longint b, input int s);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [63:0]  r;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 64'(-a) : 64'(a);
        ub   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        r    = 64'(prod >> s);
        return neg ? longint'(-r) : longint'(r);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b   = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // normalization factor in Q2.60
    function automatic longint norm_factor(input int l, input int m);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] k;
        int          e;
        int          half;
        num = 64'(2 * l + 1) * FACTORIAL[l - m] * INV_4PI_Q40;
        den = FACTORIAL[l + m];
        q   = num / den;
        r   = num % den;
        e   = 40;
        while ((q < (64'd1 << 60) || e[0]) && e < 200)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r    = r - den;
                q[0] = 1'b1;
            end
            e++;
        end
        k    = int_sqrt(q);
        half = e / 2;
        if (half <= 60)
        begin
            return longint'(k << (60 - half));
        end
        return (half - 60 < 64) ? longint'(k >> (half - 60)) : 0;
    endfunction

    // rotation-mode cordic on a 32-bit turn fraction, outputs in Q1.30
    function automatic void turn_cos_sin(input logic [31:0] turn, output longint c,
                                         output longint s);
        logic [31:0] a;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        a    = turn;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip)
        begin
            a = a - 32'h80000000;
        end
        z = longint'($signed(a));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ARCTAN_TURN[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ARCTAN_TURN[i]);
            end
        end
        if (x > UNIT_Q30) x = UNIT_Q30;
        if (x < -UNIT_Q30) x = -UNIT_Q30;
        if (y > UNIT_Q30) y = UNIT_Q30;
        if (y < -UNIT_Q30) y = -UNIT_Q30;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // associated legendre value in Q31.32
    function automatic longint legendre_q32(input int l, input int m, input longint x,
                                            input longint s);
        longint pmm;
        longint pnext;
        longint plm;
        longint ta;
        longint tb;
        pmm = UNIT_Q32;
        plm = 0;
        for (int i = 1; i <= m; i++)
        begin
            pmm = -(trunc_mul(pmm, s, 32) * longint'(2 * i - 1));
        end
        if (l == m)
        begin
            return pmm;
        end
        pnext = trunc_mul(x, pmm, 32) * longint'(2 * m + 1);
        if (l == m + 1)
        begin
            return pnext;
        end
        for (int i = m + 2; i <= l; i++)
        begin
            ta    = trunc_mul(x, pnext, 32) * longint'(2 * i - 1);
            tb    = pmm * longint'(i + m - 1);
            plm   = trunc_mul(ta - tb, INV_STEP_Q32[(i - m) & 7], 32);
            pmm   = pnext;
            pnext = plm;
        end
        return plm;
    endfunction

    function automatic harmonic_t predict_harmonic(input sample_word_t w);
        harmonic_t   h;
        int          l;
        int          m;
        int          am;
        longint      ct;
        longint      st;
        longint      cp;
        longint      sp;
        longint      v;
        logic [31:0] az_turn;
        l  = w.band;
        m  = w.order;
        am = (m < 0) ? -m : m;
        if (am > l || l >= BANDS)
        begin
            h.value   = '0;
            h.invalid = 1'b1;
            return h;
        end
        turn_cos_sin({w.polar, 16'd0}, ct, st);
        if (st < 0)
        begin
            st = -st;
        end
        v = trunc_mul(legendre_q32(l, am, ct * 4, st * 4), norm_factor(l, am), 60);
        if (m != 0)
        begin
            az_turn = 32'({w.azim, 16'd0} * am);
            turn_cos_sin(az_turn, cp, sp);
            v = trunc_mul(v, trunc_mul((m > 0) ? cp : sp, ROOT2_Q30, 30), 30);
        end
        v = trunc_mul(v, 1, 4);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        h.value   = 32'(v);
        h.invalid = 1'b0;
        return h;
    endfunction

    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        a = 16'($urandom);
        // now and then land on a quadrant edge
        if ($urandom_range(9) == 0)
        begin
            a = {2'(a), 14'd0} + 16'($signed(2'($urandom)) );
        end
        return a;
    endfunction

    task automatic queue_word(input int l, input int m, input logic [15:0] p,
                              input logic [15:0] az);
        sample_word_t w;
        w.band  = 3'(l);
        w.order = 4'(m);
        w.polar = p;
        w.azim  = az;
        pending_words.push_back(w);
    endtask

    task automatic queue_random(input int count);
        int l;
        int m;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 85)
            begin
                l = $urandom_range(7);
                m = $urandom_range(2 * l) - l;
            end
            else
            begin
                l = $urandom_range(7);
                m = int'($signed(4'($urandom)));
            end
            queue_word(l, m, pick_angle(), pick_angle());
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || start || expected_harmonics.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // driver: one word per accepted start
    always @(posedge clk)
    begin
        sample_word_t w;
        logic         take;
        if (rst_n)
        begin
            take = start && !busy;
            if (take)
            begin
                w.band  = band;
                w.order = order;
                w.polar = polar_angle;
                w.azim  = azimuth_angle;
                expected_harmonics.push_back(predict_harmonic(w));
            end
            if (!start || take)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    w             = pending_words.pop_front();
                    band          <= w.band;
                    order         <= w.order;
                    polar_angle   <= w.polar;
                    azimuth_angle <= w.azim;
                    start         <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        harmonic_t h;
        if (rst_n && done)
        begin
            if (expected_harmonics.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected result word: value %0d invalid %0b",
                             harmonic_value, invalid);
                end
            end
            else
            begin
                h = expected_harmonics.pop_front();
                if (harmonic_value !== h.value || invalid !== h.invalid)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display({"result mismatch: value exp %0d got %0d, ",
                                  "invalid exp %0b got %0b"},
                                 h.value, harmonic_value, h.invalid, invalid);
                    end
                end
            end
        end
    end

    // stimulus phases and end of run
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: band extremes, orders out of range, quadrant edges
        for (int l = 0; l < 8; l++)
        begin
            queue_word(l, 0, 16'h0000, 16'h0000);
        end
        queue_word(7, 7, 16'h4000, 16'h0000);
        queue_word(7, -7, 16'h3FFF, 16'hFFFF);
        queue_word(7, 7, 16'hFFFF, 16'h4000);
        queue_word(5, -3, 16'h8000, 16'hC000);
        queue_word(3, 2, 16'hC000, 16'h8000);
        queue_word(6, -1, 16'h2000, 16'h5555);
        queue_word(4, 4, 16'hBFFF, 16'hAAAA);
        queue_word(0, 1, 16'h1234, 16'h4321);
        queue_word(0, -1, 16'hFFFF, 16'hFFFF);
        queue_word(7, -8, 16'h4000, 16'h4000);
        queue_word(3, 4, 16'h7FFF, 16'h8001);
        queue_word(1, -7, 16'h0001, 16'h0001);
        queue_word(2, 1, 16'h4001, 16'h3FFF);
        wait_drained();

        sender_idle_pct = 0;
        queue_random(260);
        wait_drained();

        sender_idle_pct = 86;
        queue_random(200);
        wait_drained();

        sender_idle_pct = 12;
        queue_random(290);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_harmonics.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rshs_pkg.sv
rtl/rshs_mul.sv
rtl/rshs_cordic.sv
rtl/rshs_legendre.sv
rtl/real_spherical_harmonic_sample.sv
verif/tb_top.sv
